// ----- rtl/core/frame_mac_aes_checksum_iv_defines.svh -----
// Assertion macros shared by the frame MAC design
`ifndef FRAME_MAC_AES_CHECKSUM_IV_DEFINES_SVH
`define FRAME_MAC_AES_CHECKSUM_IV_DEFINES_SVH

// implication checked on every clock unless in reset
`define FMAC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define FMAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/fmac_pkg.sv -----
// Package: types, constants and AES helper functions for the frame MAC
package fmac_pkg;

    localparam logic [7:0] PAD_BYTE  = 8'h55;
    localparam logic [7:0] CHK_POLY2 = 8'h5B;
    localparam int         HEAD_MAX  = 8;
    localparam int         QUEUE_DEPTH = 2;

    localparam logic CFG_KEY_UPPER = 1'b0;
    localparam logic CFG_KEY_LOWER = 1'b1;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_RUN,
        ENG_DONE
    } eng_state_t;

    typedef struct packed {
        logic [127:0] block;
        logic [127:0] key;
    } job_t;

    function automatic logic [7:0] sbox(input logic [7:0] v);
        logic [7:0] r;
        begin
            unique case (v)
                8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
                8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
                8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
                8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
                8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
                8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
                8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
                8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
                8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
                8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
                8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
                8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
                8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
                8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
                8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
                8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
                8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
                8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
                8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
                8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
                8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
                8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
                8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
                8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
                8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
                8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
                8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
                8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
                8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
                8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
                8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
                8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
                8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
                8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
                8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
                8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
                8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
                8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
                8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
                8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
                8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
                8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
                8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
                8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
                8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
                8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
                8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
                8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
                8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
                8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
                8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
                8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
                8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
                8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
                8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
                8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
                8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
                8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
                8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
                8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
                8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
                8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
                8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
                8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit word, byte 0 most significant
    function automatic logic [7:0] byte_of(input logic [127:0] w, input int i);
        return w[127 - 8 * i -: 8];
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0] rcon);
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        logic [31:0] t;
        begin
            w0 = k[127:96];
            w1 = k[95:64];
            w2 = k[63:32];
            w3 = k[31:0];
            t = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
            w0 = w0 ^ t;
            w1 = w1 ^ w0;
            w2 = w2 ^ w1;
            w3 = w3 ^ w2;
            return {w0, w1, w2, w3};
        end
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] st,
                                               input logic [127:0] rk,
                                               input logic last_round);
        logic [7:0] t [16];
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        logic [7:0] all;
        logic [127:0] res;
        begin
            for (int c = 0; c < 4; c++) begin
                for (int i = 0; i < 4; i++) begin
                    t[i + 4 * c] = sbox(byte_of(st, i + 4 * ((c + i) % 4)));
                end
            end
            if (!last_round) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4 * c];
                    a1 = t[4 * c + 1];
                    a2 = t[4 * c + 2];
                    a3 = t[4 * c + 3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    t[4 * c]     = a0 ^ all ^ xt(a0 ^ a1);
                    t[4 * c + 1] = a1 ^ all ^ xt(a1 ^ a2);
                    t[4 * c + 2] = a2 ^ all ^ xt(a2 ^ a3);
                    t[4 * c + 3] = a3 ^ all ^ xt(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) begin
                res[127 - 8 * i -: 8] = t[i];
            end
            return res ^ rk;
        end
    endfunction

endpackage

// ----- rtl/core/fmac_front.sv -----
// Front end: checksum, head capture and block assembly per frame
module fmac_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic [15:0]         sequence_req,
    input  logic [127:0]        key,
    output logic                job_valid,
    input  logic                job_ready,
    output fmac_pkg::job_t      job
);

    logic [7:0]  check_first_reg;
    logic [7:0]  check_second_reg;
    logic [63:0] head_bytes_reg;
    logic [3:0]  head_count_reg;
    logic [7:0]  check_first_next;
    logic [7:0]  check_second_next;
    logic [63:0] head_bytes_next;
    logic [3:0]  head_count_next;
    logic [7:0]  mix;
    logic [7:0]  nf;
    logic        accept;
    logic [63:0] head_block;

    // a byte that ends a frame needs a queue slot
    assign in_ready = !last_byte || job_ready;
    assign accept   = in_valid && in_ready;
    assign job_valid = in_valid && last_byte;

    always_comb
    begin
        mix = data_byte ^ check_second_reg;
        nf  = {check_first_reg[6:0], mix[7]};
        if (check_first_reg[7])
        begin
            check_first_next  = nf ^ fmac_pkg::PAD_BYTE;
            check_second_next = {mix[6:0], 1'b0} ^ fmac_pkg::CHK_POLY2;
        end
        else
        begin
            check_first_next  = nf;
            check_second_next = {mix[6:0], 1'b0};
        end
        head_bytes_next = head_bytes_reg;
        head_count_next = head_count_reg;
        if (head_count_reg < 4'(fmac_pkg::HEAD_MAX))
        begin
            head_bytes_next[63 - 8 * head_count_reg[2:0] -: 8] = data_byte;
            head_count_next = head_count_reg + 4'd1;
        end
        for (int i = 0; i < fmac_pkg::HEAD_MAX; i++)
        begin
            head_block[63 - 8 * i -: 8] = (4'(i) < head_count_next)
                ? head_bytes_next[63 - 8 * i -: 8] : fmac_pkg::PAD_BYTE;
        end
        job.block = {head_block, check_first_next, check_second_next, sequence_req,
                     {4{fmac_pkg::PAD_BYTE}}};
        job.key   = key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_first_reg  <= '0;
            check_second_reg <= '0;
            head_bytes_reg   <= '0;
            head_count_reg   <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                check_first_reg  <= '0;
                check_second_reg <= '0;
                head_bytes_reg   <= '0;
                head_count_reg   <= '0;
            end
            else
            begin
                check_first_reg  <= check_first_next;
                check_second_reg <= check_second_next;
                head_bytes_reg   <= head_bytes_next;
                head_count_reg   <= head_count_next;
            end
        end
    end

endmodule

// ----- rtl/core/fmac_queue.sv -----
// Job queue between the front end and the AES engine
module fmac_queue #(
    parameter int DEPTH = fmac_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  fmac_pkg::job_t wr_job,
    output logic           rd_valid,
    input  logic           rd_ready,
    output fmac_pkg::job_t rd_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    fmac_pkg::job_t     mem [DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [AW:0]        count_reg;
    logic               push;
    logic               pop;

    assign wr_ready = count_reg != (AW + 1)'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_job   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW + 1)'(push) - (AW + 1)'(pop);
        end
    end

endmodule

// ----- rtl/core/fmac_engine.sv -----
// Iterative AES-128 engine: one round per cycle with on-the-fly key expansion
module fmac_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  fmac_pkg::job_t job,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [47:0]    mac
);

    `include "frame_mac_aes_checksum_iv_defines.svh"

    fmac_pkg::eng_state_t state_reg;
    fmac_pkg::eng_state_t state_next;
    logic [127:0] st_reg;
    logic [127:0] rk_reg;
    logic [7:0]   rcon_reg;
    logic [3:0]   round_reg;
    logic [127:0] rk_new;
    logic [127:0] st_new;
    logic         load;
    logic         step;

    assign rk_new = fmac_pkg::next_round_key(rk_reg, rcon_reg);
    assign st_new = fmac_pkg::aes_round(st_reg, rk_new, round_reg == 4'd10);
    assign mac    = st_reg[127:80];

    always_comb
    begin
        state_next = state_reg;
        job_ready  = 1'b0;
        out_valid  = 1'b0;
        load       = 1'b0;
        step       = 1'b0;
        unique case (state_reg)
            fmac_pkg::ENG_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    load       = 1'b1;
                    state_next = fmac_pkg::ENG_RUN;
                end
            end
            fmac_pkg::ENG_RUN:
            begin
                step = 1'b1;
                if (round_reg == 4'd10)
                begin
                    state_next = fmac_pkg::ENG_DONE;
                end
            end
            fmac_pkg::ENG_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    job_ready = 1'b1;
                    if (job_valid)
                    begin
                        load       = 1'b1;
                        state_next = fmac_pkg::ENG_RUN;
                    end
                    else
                    begin
                        state_next = fmac_pkg::ENG_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = fmac_pkg::ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fmac_pkg::ENG_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                round_reg <= 4'd1;
            end
            else if (step)
            begin
                round_reg <= round_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            st_reg   <= job.block ^ job.key;
            rk_reg   <= job.key;
            rcon_reg <= 8'h01;
        end
        else if (step)
        begin
            st_reg   <= st_new;
            rk_reg   <= rk_new;
            rcon_reg <= fmac_pkg::xt(rcon_reg);
        end
    end

    `FMAC_ASSERT_IMP(a_run_round_range, state_reg == fmac_pkg::ENG_RUN,
        round_reg >= 4'd1 && round_reg <= 4'd10)
    `FMAC_ASSERT_NEXT(a_load_starts_run, load,
        state_reg == fmac_pkg::ENG_RUN && round_reg == 4'd1)
    `FMAC_ASSERT_NEXT(a_last_round_done, state_reg == fmac_pkg::ENG_RUN && round_reg == 4'd10,
        state_reg == fmac_pkg::ENG_DONE)
    `FMAC_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
        out_valid && $stable(mac))

endmodule

// ----- rtl/core/frame_mac_aes_checksum_iv.sv -----
// Frame MAC top: byte-rate checksum front end, job queue, iterative AES back end
// A frame's MAC appears once its job has left the queue and all AES rounds are done.
// One byte per cycle, except that a frame's last byte waits for a free queue slot.
// The two-entry job queue lets a new frame stream in while the engine works.
// Reset (rst_n low, asynchronous) clears the key, frame state, queue and engine.
module frame_mac_aes_checksum_iv #(
    parameter int QUEUE_DEPTH = fmac_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [15:0] sequence_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] mac,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0]    key_upper_reg;
    logic [63:0]    key_lower_reg;
    logic           fq_valid;
    logic           fq_ready;
    fmac_pkg::job_t fq_job;
    logic           qe_valid;
    logic           qe_ready;
    fmac_pkg::job_t qe_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fmac_pkg::CFG_KEY_UPPER: key_upper_reg <= cfg_data;
                fmac_pkg::CFG_KEY_LOWER: key_lower_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    fmac_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .sequence_req (sequence_req),
        .key          ({key_upper_reg, key_lower_reg}),
        .job_valid    (fq_valid),
        .job_ready    (fq_ready),
        .job          (fq_job)
    );

    fmac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_job   (fq_job),
        .rd_valid (qe_valid),
        .rd_ready (qe_ready),
        .rd_job   (qe_job)
    );

    fmac_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qe_valid),
        .job_ready (qe_ready),
        .job       (qe_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .mac       (mac)
    );

endmodule

// ----- verif/frame_mac_aes_checksum_iv_test.sv -----
// Self-checking regression for the keyed frame MAC: AES-128 over checksum, head bytes and sequence
module frame_mac_aes_checksum_iv_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic [15:0] sequence_req = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [47:0] mac;
    logic        cfg_we = 1'b0;
    logic        cfg_index = fmac_pkg::CFG_KEY_UPPER;
    logic [63:0] cfg_data = '0;

    frame_mac_aes_checksum_iv uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [7:0]  sb [256];
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [63:0] head;
    int          head_n;
    logic [47:0] mac_queue[$];
    int          fail_count;
    int          frames_sent;
    int          items_sent;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_recv;

    function automatic logic [7:0] dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic void fill_sbox();
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] x;
        p = 8'h01;
        q = 8'h01;
        sb[0] = 8'h63;
        do
        begin
            p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
            q = q ^ {q[6:0], 1'b0};
            q = q ^ {q[5:0], 2'b0};
            q = q ^ {q[3:0], 4'b0};
            if (q[7])
                q = q ^ 8'h09;
            x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
                ^ {q[3:0], q[7:4]};
            sb[p] = x ^ 8'h63;
        end
        while (p != 8'h01);
    endfunction

    function automatic logic [127:0] encrypt_block(input logic [127:0] k, input logic [127:0] pt);
        logic [7:0]  st [16];
        logic [7:0]  tm [16];
        logic [7:0]  rk [16];
        logic [7:0]  t0;
        logic [7:0]  t1;
        logic [7:0]  t2;
        logic [7:0]  t3;
        logic [7:0]  s;
        logic [7:0]  rc;
        logic [7:0]  a0;
        logic [7:0]  a1;
        logic [7:0]  a2;
        logic [7:0]  a3;
        logic [7:0]  al;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = k[127 - 8 * i -: 8];
            st[i] = pt[127 - 8 * i -: 8] ^ rk[i];
        end
        for (int r = 1; r <= 10; r++)
        begin
            s = rk[12];
            t0 = sb[rk[13]] ^ rc;
            t1 = sb[rk[14]];
            t2 = sb[rk[15]];
            t3 = sb[s];
            rc = dbl(rc);
            for (int w = 0; w < 4; w++)
            begin
                rk[4 * w] = rk[4 * w] ^ t0;
                rk[4 * w + 1] = rk[4 * w + 1] ^ t1;
                rk[4 * w + 2] = rk[4 * w + 2] ^ t2;
                rk[4 * w + 3] = rk[4 * w + 3] ^ t3;
                t0 = rk[4 * w];
                t1 = rk[4 * w + 1];
                t2 = rk[4 * w + 2];
                t3 = rk[4 * w + 3];
            end
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    tm[i + 4 * c] = sb[st[i + 4 * ((c + i) % 4)]];
            if (r < 10)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = tm[4 * c];
                    a1 = tm[4 * c + 1];
                    a2 = tm[4 * c + 2];
                    a3 = tm[4 * c + 3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    tm[4 * c] = a0 ^ al ^ dbl(a0 ^ a1);
                    tm[4 * c + 1] = a1 ^ al ^ dbl(a1 ^ a2);
                    tm[4 * c + 2] = a2 ^ al ^ dbl(a2 ^ a3);
                    tm[4 * c + 3] = a3 ^ al ^ dbl(a3 ^ a0);
                end
            for (int i = 0; i < 16; i++)
                st[i] = tm[i] ^ rk[i];
        end
        for (int i = 0; i < 16; i++)
            res[127 - 8 * i -: 8] = st[i];
        return res;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b, input logic fin,
                                        input logic [15:0] seq);
        logic [7:0]   mix;
        logic [7:0]   nf;
        logic [127:0] blk;
        logic [127:0] ct;
        mix = b ^ sum_b;
        nf = {sum_a[6:0], mix[7]};
        if (sum_a[7])
        begin
            sum_a = nf ^ fmac_pkg::PAD_BYTE;
            sum_b = {mix[6:0], 1'b0} ^ fmac_pkg::CHK_POLY2;
        end
        else
        begin
            sum_a = nf;
            sum_b = {mix[6:0], 1'b0};
        end
        if (head_n < fmac_pkg::HEAD_MAX)
        begin
            head[63 - 8 * head_n -: 8] = b;
            head_n++;
        end
        if (fin)
        begin
            for (int i = 0; i < 8; i++)
                blk[127 - 8 * i -: 8] = (i < head_n) ? head[63 - 8 * i -: 8]
                                                     : fmac_pkg::PAD_BYTE;
            blk[63:0] = {sum_a, sum_b, seq, {4{fmac_pkg::PAD_BYTE}}};
            ct = encrypt_block({key_hi, key_lo}, blk);
            mac_queue.push_back(ct[127:80]);
            sum_a = '0;
            sum_b = '0;
            head = '0;
            head_n = 0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic [15:0] seq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        sequence_req <= seq;
        do
            @(posedge clk);
        while (!in_ready);
        absorb_byte(b, fin, seq);
        items_sent++;
        if (fin)
            frames_sent++;
    endtask

    task automatic send_frame(input int len, input bit rand_data, input logic [7:0] fixed);
        for (int i = 0; i < len; i++)
            send_byte(rand_data ? 8'($urandom) : fixed, i == len - 1, 16'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (mac_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_key(input logic idx, input logic [63:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == fmac_pkg::CFG_KEY_UPPER)
            key_hi = v;
        else
            key_lo = v;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (mac_queue.size() == 0)
            begin
                $display("%0t unexpected mac: expected none, actual %h", $time, mac);
                fail_count++;
            end
            else if (mac !== mac_queue[0])
            begin
                $display("%0t mac mismatch: expected %h, actual %h", $time, mac_queue[0], mac);
                fail_count++;
                void'(mac_queue.pop_front());
            end
            else
                void'(mac_queue.pop_front());
        end
        out_ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_byte(8'h00, 1'b1, 16'h0000);
        send_byte(8'hff, 1'b1, 16'hffff);
        send_frame(8, 0, 8'hff);
        send_frame(9, 0, 8'h80);
        send_frame(20, 0, 8'h7f);
        send_frame(3, 1, 8'h00);
        drain();
        write_key(fmac_pkg::CFG_KEY_UPPER, 64'hffff_ffff_ffff_ffff);
        write_key(fmac_pkg::CFG_KEY_LOWER, 64'hffff_ffff_ffff_ffff);
        send_frame(7, 1, 8'h00);
        send_byte(8'h12, 1'b0, 16'h0);
        drain();
        write_key(fmac_pkg::CFG_KEY_LOWER, 64'h0123_4567_89ab_cdef);
        send_byte(8'h34, 1'b1, 16'h8001);
        drain();
    endtask

    task automatic test_random(input int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items)
            send_frame(($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 9),
                       1, 8'h00);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_recv = 1'b0;
            end
            repeat (12) send_frame($urandom_range(1, 3), 1, 8'h00);
        join
        drain();
    endtask

    initial
    begin
        fill_sbox();
        key_hi = '0;
        key_lo = '0;
        sum_a = '0;
        sum_b = '0;
        head = '0;
        head_n = 0;
        fail_count = 0;
        frames_sent = 0;
        items_sent = 0;
        hold_recv = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        write_key(fmac_pkg::CFG_KEY_UPPER, {$urandom, $urandom});
        write_key(fmac_pkg::CFG_KEY_LOWER, {$urandom, $urandom});
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(120);
        send_idle_pct = 57;
        test_random(120);
        drain();
        write_key(fmac_pkg::CFG_KEY_UPPER, 64'h0);
        write_key(fmac_pkg::CFG_KEY_LOWER, {$urandom, $urandom});
        send_idle_pct = 0;
        recv_stall_pct = 57;
        test_random(120);
        send_idle_pct = 8;
        recv_stall_pct = 8;
        test_random(120);
        drain();
        $display("covered %0d bytes in %0d frames over several keys and idle/stall mixes",
                 items_sent, frames_sent);
        if (fail_count == 0)
            $display("frame_mac_aes_checksum_iv regression: pass");
        else
            $display("frame_mac_aes_checksum_iv regression: fail");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("frame_mac_aes_checksum_iv regression: fail");
        $finish;
    end
endmodule
